// ===== design/acp_pkg.sv =====
// ----------------------------------------------------------------------------
// acp_pkg: shared types and helpers for the AABB push-out block
// Q16.16 value types, stage words, register indexes and saturation.
// ----------------------------------------------------------------------------
package acp_pkg;

  // signed Q16.16 coordinate
  typedef logic signed [31:0] q_t;
  // unsigned 31-bit configuration value (Q16.16, non-negative)
  typedef logic [30:0] cfg_val_t;
  // non-negative overlap, fits 31 bits after saturation
  typedef logic [30:0] ovl_t;
  // configuration register index
  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_BOX_HALF_WIDTH = 2'd0;
  localparam cfg_idx_t CFG_EYE_HEIGHT     = 2'd1;
  localparam cfg_idx_t CFG_CUBE_EDGE      = 2'd2;

  localparam cfg_val_t RST_BOX_HALF_WIDTH = 31'd13107;
  localparam cfg_val_t RST_EYE_HEIGHT     = 31'd104858;
  localparam cfg_val_t RST_CUBE_EDGE      = 31'd65536;

  localparam logic signed [33:0] Q_MAX_W = 34'sd2147483647;
  localparam logic signed [33:0] Q_MIN_W = -34'sd2147483648;

  // interval of one axis: camera box and cube
  typedef struct packed {
    q_t box_lo;
    q_t box_hi;
    q_t cube_lo;
    q_t cube_hi;
  } axis_bounds_t;

  // word after the bounds stage
  typedef struct packed {
    axis_bounds_t x;
    axis_bounds_t y;
    axis_bounds_t z;
    q_t           cam_x;
    q_t           cam_y;
    q_t           cam_z;
    logic         last;
  } bnd_word_t;

  // word after the overlap stage
  typedef struct packed {
    ovl_t ox;
    ovl_t oy;
    ovl_t oz;
    q_t   cam_x;
    q_t   cam_y;
    q_t   cam_z;
    logic last;
  } ovl_word_t;

  // clamp a wide signed sum into the signed 32-bit range
  function automatic q_t sat_q(input logic signed [33:0] v);
    q_t r;
    if (v > Q_MAX_W) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < Q_MIN_W) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // sign-extend a coordinate to the wide sum width
  function automatic logic signed [33:0] ext_q(input q_t v);
    return $signed({{2{v[31]}}, v});
  endfunction

  // zero-extend a non-negative 31-bit value to the wide sum width
  function automatic logic signed [33:0] ext_u(input logic [30:0] v);
    return $signed({3'b000, v});
  endfunction

endpackage

// ===== design/acp_bounds.sv =====
// ----------------------------------------------------------------------------
// acp_bounds: box and cube corners
// Forms the saturated camera box and cube intervals per axis and registers them.
// ----------------------------------------------------------------------------
module acp_bounds (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_vld,
  input  acp_pkg::q_t          cam_x,
  input  acp_pkg::q_t          cam_y,
  input  acp_pkg::q_t          cam_z,
  input  acp_pkg::q_t          cube_x,
  input  acp_pkg::q_t          cube_y,
  input  acp_pkg::q_t          cube_z,
  input  logic                 last,
  input  acp_pkg::cfg_val_t    half_width,
  input  acp_pkg::cfg_val_t    eye_height,
  input  acp_pkg::cfg_val_t    cube_edge,
  output logic                 out_vld,
  output acp_pkg::bnd_word_t   out_word
);
  import acp_pkg::*;

  bnd_word_t word_nxt;
  bnd_word_t word_r;
  logic      vld_r;

  // one saturating add for each offset corner, all in parallel
  always_comb begin
    word_nxt.x.box_lo  = sat_q(ext_q(cam_x) - ext_u(half_width));
    word_nxt.x.box_hi  = sat_q(ext_q(cam_x) + ext_u(half_width));
    word_nxt.x.cube_lo = cube_x;
    word_nxt.x.cube_hi = sat_q(ext_q(cube_x) + ext_u(cube_edge));
    word_nxt.y.box_lo  = sat_q(ext_q(cam_y) - ext_u(eye_height));
    word_nxt.y.box_hi  = cam_y;
    word_nxt.y.cube_lo = cube_y;
    word_nxt.y.cube_hi = sat_q(ext_q(cube_y) + ext_u(cube_edge));
    word_nxt.z.box_lo  = sat_q(ext_q(cam_z) - ext_u(half_width));
    word_nxt.z.box_hi  = sat_q(ext_q(cam_z) + ext_u(half_width));
    word_nxt.z.cube_lo = cube_z;
    word_nxt.z.cube_hi = sat_q(ext_q(cube_z) + ext_u(cube_edge));
    word_nxt.cam_x     = cam_x;
    word_nxt.cam_y     = cam_y;
    word_nxt.cam_z     = cam_z;
    word_nxt.last      = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_r <= word_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;

endmodule

// ===== design/acp_overlap.sv =====
// ----------------------------------------------------------------------------
// acp_overlap: per-axis overlap
// Overlap of box and cube on each axis, saturated and clamped at zero.
// ----------------------------------------------------------------------------
module acp_overlap (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  acp_pkg::bnd_word_t  in_word,
  output logic                out_vld,
  output acp_pkg::ovl_word_t  out_word
);
  import acp_pkg::*;

  ovl_word_t word_nxt;
  ovl_word_t word_r;
  logic      vld_r;

  // min(hi) - max(lo), negative or zero means no overlap
  function automatic ovl_t axis_ovl(input axis_bounds_t b);
    q_t   lo;
    q_t   hi;
    q_t   d;
    ovl_t r;
    lo = (b.box_lo > b.cube_lo) ? b.box_lo : b.cube_lo;
    hi = (b.box_hi < b.cube_hi) ? b.box_hi : b.cube_hi;
    d  = sat_q(ext_q(hi) - ext_q(lo));
    if (d > 32'sd0) begin
      r = d[30:0];
    end else begin
      r = '0;
    end
    return r;
  endfunction

  always_comb begin
    word_nxt.ox    = axis_ovl(in_word.x);
    word_nxt.oy    = axis_ovl(in_word.y);
    word_nxt.oz    = axis_ovl(in_word.z);
    word_nxt.cam_x = in_word.cam_x;
    word_nxt.cam_y = in_word.cam_y;
    word_nxt.cam_z = in_word.cam_z;
    word_nxt.last  = in_word.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_r <= word_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;

endmodule

// ===== design/acp_resolve.sv =====
// ----------------------------------------------------------------------------
// acp_resolve: push-out and scan state
// Picks the least-overlap axis, keeps the first hit of a scan and loads the
// result register at the end of the scan.
// ----------------------------------------------------------------------------
module acp_resolve (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  acp_pkg::ovl_word_t  in_word,
  output logic                res_vld,
  output acp_pkg::q_t         res_x,
  output acp_pkg::q_t         res_y,
  output acp_pkg::q_t         res_z,
  output logic                res_collided
);
  import acp_pkg::*;

  logic hit;
  logic sel_x;
  logic sel_y;
  q_t   push_x;
  q_t   push_y;
  q_t   push_z;
  q_t   cur_x;
  q_t   cur_y;
  q_t   cur_z;
  q_t   pos_x;
  q_t   pos_y;
  q_t   pos_z;
  logic coll;

  logic hit_seen_r;
  q_t   hit_x_r;
  q_t   hit_y_r;
  q_t   hit_z_r;
  logic res_vld_r;
  q_t   res_x_r;
  q_t   res_y_r;
  q_t   res_z_r;
  logic res_coll_r;

  // axis choice, ties to x then y
  always_comb begin
    hit   = (in_word.ox != '0) && (in_word.oy != '0) && (in_word.oz != '0);
    sel_x = (in_word.ox <= in_word.oy) && (in_word.ox <= in_word.oz);
    sel_y = (in_word.oy <= in_word.ox) && (in_word.oy <= in_word.oz);
  end

  // pushed candidates, computed in parallel
  always_comb begin
    push_x = sat_q(ext_q(in_word.cam_x) + ext_u(in_word.ox));
    push_y = sat_q(ext_q(in_word.cam_y) + ext_u(in_word.oy));
    push_z = sat_q(ext_q(in_word.cam_z) + ext_u(in_word.oz));
    cur_x  = in_word.cam_x;
    cur_y  = in_word.cam_y;
    cur_z  = in_word.cam_z;
    if (sel_x) begin
      cur_x = push_x;
    end else if (sel_y) begin
      cur_y = push_y;
    end else begin
      cur_z = push_z;
    end
  end

  // position the scan reports: earlier hit wins, then this item
  always_comb begin
    if (hit_seen_r) begin
      pos_x = hit_x_r;
      pos_y = hit_y_r;
      pos_z = hit_z_r;
    end else if (hit) begin
      pos_x = cur_x;
      pos_y = cur_y;
      pos_z = cur_z;
    end else begin
      pos_x = in_word.cam_x;
      pos_y = in_word.cam_y;
      pos_z = in_word.cam_z;
    end
    coll = hit_seen_r | hit;
  end

  // scan state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_seen_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else if (adv) begin
      res_vld_r <= in_vld & in_word.last;
      if (in_vld) begin
        if (in_word.last) begin
          hit_seen_r <= 1'b0;
        end else if (hit) begin
          hit_seen_r <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv && in_vld && !hit_seen_r && hit) begin
      hit_x_r <= cur_x;
      hit_y_r <= cur_y;
      hit_z_r <= cur_z;
    end
    if (adv) begin
      res_x_r    <= pos_x;
      res_y_r    <= pos_y;
      res_z_r    <= pos_z;
      res_coll_r <= coll;
    end
  end

  assign res_vld      = res_vld_r;
  assign res_x        = res_x_r;
  assign res_y        = res_y_r;
  assign res_z        = res_z_r;
  assign res_collided = res_coll_r;

endmodule

// ===== design/aabb_collision_pushout.sv =====
// ----------------------------------------------------------------------------
// aabb_collision_pushout: camera box push-out against a stream of cubes
// Top level: input register, config registers and the three pipeline stages.
// ----------------------------------------------------------------------------
// The block takes one cube word per clock while in_ready is high and emits one
// result word per scan, on the word marked last (the accepting edge loads the
// input register, then the word passes the bounds, overlap and result
// registers in turn). The pipeline advances as a whole whenever the result
// register is empty or being taken, so in_ready drops only while a finished
// result waits on out_ready. Configuration registers may be written only
// while no word is in flight.
module aabb_collision_pushout (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  acp_pkg::q_t       in_cam_x,
  input  acp_pkg::q_t       in_cam_y,
  input  acp_pkg::q_t       in_cam_z,
  input  acp_pkg::q_t       in_cube_x,
  input  acp_pkg::q_t       in_cube_y,
  input  acp_pkg::q_t       in_cube_z,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output acp_pkg::q_t       out_new_x,
  output acp_pkg::q_t       out_new_y,
  output acp_pkg::q_t       out_new_z,
  output logic              out_collided,
  input  logic              cfg_we,
  input  acp_pkg::cfg_idx_t cfg_index,
  input  acp_pkg::cfg_val_t cfg_wdata
);
  import acp_pkg::*;

  logic      adv;
  logic      s1_vld_r;
  q_t        s1_cam_x_r;
  q_t        s1_cam_y_r;
  q_t        s1_cam_z_r;
  q_t        s1_cube_x_r;
  q_t        s1_cube_y_r;
  q_t        s1_cube_z_r;
  logic      s1_last_r;
  cfg_val_t  half_width_r;
  cfg_val_t  eye_height_r;
  cfg_val_t  cube_edge_r;
  logic      s2_vld;
  bnd_word_t s2_word;
  logic      s3_vld;
  ovl_word_t s3_word;

  // whole pipe moves when the result slot is free
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= RST_BOX_HALF_WIDTH;
      eye_height_r <= RST_EYE_HEIGHT;
      cube_edge_r  <= RST_CUBE_EDGE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_HALF_WIDTH: half_width_r <= cfg_wdata;
        CFG_EYE_HEIGHT:     eye_height_r <= cfg_wdata;
        CFG_CUBE_EDGE:      cube_edge_r  <= cfg_wdata;
        default:            ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cam_x_r  <= in_cam_x;
      s1_cam_y_r  <= in_cam_y;
      s1_cam_z_r  <= in_cam_z;
      s1_cube_x_r <= in_cube_x;
      s1_cube_y_r <= in_cube_y;
      s1_cube_z_r <= in_cube_z;
      s1_last_r   <= in_last;
    end
  end

  acp_bounds u_bounds (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_vld     (s1_vld_r),
    .cam_x      (s1_cam_x_r),
    .cam_y      (s1_cam_y_r),
    .cam_z      (s1_cam_z_r),
    .cube_x     (s1_cube_x_r),
    .cube_y     (s1_cube_y_r),
    .cube_z     (s1_cube_z_r),
    .last       (s1_last_r),
    .half_width (half_width_r),
    .eye_height (eye_height_r),
    .cube_edge  (cube_edge_r),
    .out_vld    (s2_vld),
    .out_word   (s2_word)
  );

  acp_overlap u_overlap (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (s2_vld),
    .in_word  (s2_word),
    .out_vld  (s3_vld),
    .out_word (s3_word)
  );

  acp_resolve u_resolve (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_vld       (s3_vld),
    .in_word      (s3_word),
    .res_vld      (out_valid),
    .res_x        (out_new_x),
    .res_y        (out_new_y),
    .res_z        (out_new_z),
    .res_collided (out_collided)
  );

endmodule

// ===== design/acp_checker.sv =====
// ----------------------------------------------------------------------------
// acp_props: port-level checks for the push-out block
// Watches handshake and stall behavior at the top-level ports.
// ----------------------------------------------------------------------------
module acp_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_new_x,
  input logic        out_collided
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_x) && $stable(out_collided))
    else $error("result word changed while stalled");

  // no result straight after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // empty result slot never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result slot");

  // a held result stalls the input
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

endmodule

bind aabb_collision_pushout acp_props u_acp_props (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_new_x    (out_new_x),
  .out_collided (out_collided)
);

// ===== test/acp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acp_checker: scoreboard for the AABB push-out block
// Tracks the config registers, predicts the resolved camera position of each
// scan from the accepted cube words and compares every result word against
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module acp_checker
  import acp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  q_t       in_cam_x,
  input  q_t       in_cam_y,
  input  q_t       in_cam_z,
  input  q_t       in_cube_x,
  input  q_t       in_cube_y,
  input  q_t       in_cube_z,
  input  logic     in_last,
  input  logic     out_valid,
  input  logic     out_ready,
  input  q_t       out_new_x,
  input  q_t       out_new_y,
  input  q_t       out_new_z,
  input  logic     out_collided,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_index,
  input  cfg_val_t cfg_wdata,
  output int       fail_count,
  output int       pending_count
);

  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;

  typedef struct packed {
    q_t   x;
    q_t   y;
    q_t   z;
    logic collided;
  } resolved_t;

  // predicted result words, oldest first
  resolved_t resolved_q[$];

  // register copies
  cfg_val_t half_w;
  cfg_val_t eye_h;
  cfg_val_t edge_len;

  // first hit of the scan in progress
  logic hit_held;
  q_t   held_x;
  q_t   held_y;
  q_t   held_z;

  function automatic longint clip_q(input longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // overlap of two intervals, never negative
  function automatic longint axis_overlap(input longint alo, input longint ahi,
                                          input longint blo, input longint bhi);
    longint d;
    d = clip_q(((ahi < bhi) ? ahi : bhi) - ((alo > blo) ? alo : blo));
    return (d > 0) ? d : 0;
  endfunction

  // fold one cube word into the scan; returns 1 when it closes the scan
  function automatic bit predict_word(input q_t cx, input q_t cy, input q_t cz,
                                      input q_t bx, input q_t by, input q_t bz,
                                      input logic lst, output resolved_t res);
    longint hw, eh, ed, ox, oy, oz;
    hw = half_w;
    eh = eye_h;
    ed = edge_len;
    if (!hit_held) begin
      ox = axis_overlap(clip_q(cx - hw), clip_q(cx + hw), bx, clip_q(bx + ed));
      oy = axis_overlap(clip_q(cy - eh), cy, by, clip_q(by + ed));
      oz = axis_overlap(clip_q(cz - hw), clip_q(cz + hw), bz, clip_q(bz + ed));
      if (ox > 0 && oy > 0 && oz > 0) begin
        held_x = cx;
        held_y = cy;
        held_z = cz;
        // push along the least overlap, ties to x then y
        if (ox <= oy && ox <= oz) begin
          held_x = q_t'(clip_q(cx + ox));
        end else if (oy <= ox && oy <= oz) begin
          held_y = q_t'(clip_q(cy + oy));
        end else begin
          held_z = q_t'(clip_q(cz + oz));
        end
        hit_held = 1'b1;
      end
    end
    if (hit_held) begin
      res = '{held_x, held_y, held_z, 1'b1};
    end else begin
      res = '{cx, cy, cz, 1'b0};
    end
    if (lst) begin
      hit_held = 1'b0;
      held_x = '0;
      held_y = '0;
      held_z = '0;
    end
    return lst;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    resolved_t want;
    resolved_t fresh;
    if (!rst_n) begin
      half_w = RST_BOX_HALF_WIDTH;
      eye_h = RST_EYE_HEIGHT;
      edge_len = RST_CUBE_EDGE;
      hit_held = 1'b0;
      held_x = '0;
      held_y = '0;
      held_z = '0;
      resolved_q.delete();
      fail_count = 0;
      pending_count <= 0;
    end else begin
      // register writes; undecoded indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          CFG_BOX_HALF_WIDTH: half_w = cfg_wdata;
          CFG_EYE_HEIGHT:     eye_h = cfg_wdata;
          CFG_CUBE_EDGE:      edge_len = cfg_wdata;
          default: ;
        endcase
      end

      // result word against the oldest prediction
      if (out_valid && out_ready) begin
        if (resolved_q.size() == 0) begin
          $error("result word with nothing predicted: new_x %0d new_y %0d new_z %0d",
                 out_new_x, out_new_y, out_new_z);
          fail_count++;
        end else begin
          want = resolved_q.pop_front();
          check_field("new_x", want.x, out_new_x);
          check_field("new_y", want.y, out_new_y);
          check_field("new_z", want.z, out_new_z);
          check_field("collided", want.collided, out_collided);
        end
      end

      // accepted cube word
      if (in_valid && in_ready) begin
        if (predict_word(in_cam_x, in_cam_y, in_cam_z, in_cube_x, in_cube_y,
                         in_cube_z, in_last, fresh)) begin
          resolved_q.push_back(fresh);
        end
      end

      pending_count <= resolved_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for aabb_collision_pushout
// Drives directed scans (axis ties, misses, camera moves, extreme positions)
// and then random scans under a series of register settings, with random
// gaps on both channels. The checker beside the block does the prediction.
// ----------------------------------------------------------------------------
module tb;
  import acp_pkg::*;

  localparam int       PIPE_DEPTH = 4;
  localparam int       ONE = 65536;
  localparam int       WORDS_PER_PHASE = 125;
  localparam int       NUM_PHASES = 12;
  localparam cfg_idx_t CFG_SPARE = 2'd3;  // not decoded by the block
  localparam cfg_val_t CFG_TOP = 31'h7FFF_FFFF;
  localparam q_t       Q_TOP = 32'sh7FFF_FFFF;
  localparam q_t       Q_BOT = 32'sh8000_0000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  q_t       in_cam_x;
  q_t       in_cam_y;
  q_t       in_cam_z;
  q_t       in_cube_x;
  q_t       in_cube_y;
  q_t       in_cube_z;
  logic     in_last;
  logic     out_valid;
  logic     out_ready;
  q_t       out_new_x;
  q_t       out_new_y;
  q_t       out_new_z;
  logic     out_collided;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  cfg_val_t cfg_wdata;

  int       fail_count;
  int       pending_count;
  int       words_sent;
  bit       calm;

  // register values in force, used to aim cubes at the camera box
  cfg_val_t half_w = RST_BOX_HALF_WIDTH;
  cfg_val_t eye_h = RST_EYE_HEIGHT;
  cfg_val_t edge_len = RST_CUBE_EDGE;

  aabb_collision_pushout u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cam_x     (in_cam_x),
    .in_cam_y     (in_cam_y),
    .in_cam_z     (in_cam_z),
    .in_cube_x    (in_cube_x),
    .in_cube_y    (in_cube_y),
    .in_cube_z    (in_cube_z),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_new_x    (out_new_x),
    .out_new_y    (out_new_y),
    .out_new_z    (out_new_z),
    .out_collided (out_collided),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  acp_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cam_x      (in_cam_x),
    .in_cam_y      (in_cam_y),
    .in_cam_z      (in_cam_z),
    .in_cube_x     (in_cube_x),
    .in_cube_y     (in_cube_y),
    .in_cube_z     (in_cube_z),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_new_x     (out_new_x),
    .out_new_y     (out_new_y),
    .out_new_z     (out_new_z),
    .out_collided  (out_collided),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // mostly small coordinates, some full range, some hugging either limit
  function automatic q_t rand_coord();
    case ($urandom_range(0, 7))
      0: return q_t'($urandom);
      1: return Q_TOP - q_t'($urandom_range(0, 4 * ONE));
      2: return Q_BOT + q_t'($urandom_range(0, 4 * ONE));
      default: return q_t'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
    endcase
  endfunction

  // c plus an offset in [lo_off, hi_off], wrapping at 32 bits
  function automatic q_t near(input q_t c, input longint lo_off, input longint hi_off);
    longint unsigned w;
    w = longint'(hi_off - lo_off);
    return q_t'(longint'(c) + lo_off + longint'({$urandom, $urandom} % (w + 1)));
  endfunction

  task automatic send_word(input q_t cx, input q_t cy, input q_t cz,
                           input q_t bx, input q_t by, input q_t bz, input logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cam_x <= cx;
    in_cam_y <= cy;
    in_cam_z <= cz;
    in_cube_x <= bx;
    in_cube_y <= by;
    in_cube_z <= bz;
    in_last <= lst;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // wait out every pending result and the words still in the pipe
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic set_regs(input cfg_val_t hw, input cfg_val_t eh, input cfg_val_t ed);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BOX_HALF_WIDTH;
    cfg_wdata <= hw;
    @(posedge clk);
    cfg_index <= CFG_EYE_HEIGHT;
    cfg_wdata <= eh;
    @(posedge clk);
    cfg_index <= CFG_CUBE_EDGE;
    cfg_wdata <= ed;
    @(posedge clk);
    // undecoded index must leave all three alone
    cfg_index <= CFG_SPARE;
    cfg_wdata <= cfg_val_t'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    half_w = hw;
    eye_h = eh;
    edge_len = ed;
  endtask

  // one scan: mostly cubes placed around the camera box, some stray ones
  task automatic run_scan();
    int     len;
    q_t     cx, cy, cz;
    longint hw, eh, ed;
    hw = half_w;
    eh = eye_h;
    ed = edge_len;
    len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 12);
    cx = rand_coord();
    cy = rand_coord();
    cz = rand_coord();
    for (int i = 0; i < len; i++) begin
      // camera moves mid-scan now and then
      if ($urandom_range(0, 9) == 0) begin
        cx = rand_coord();
        cy = rand_coord();
        cz = rand_coord();
      end
      if ($urandom_range(0, 3) == 0) begin
        send_word(cx, cy, cz, rand_coord(), rand_coord(), rand_coord(), i == len - 1);
      end else begin
        send_word(cx, cy, cz,
                  near(cx, -(hw + ed + 8), hw + 8),
                  near(cy, -(eh + ed + 8), 8),
                  near(cz, -(hw + ed + 8), hw + 8),
                  i == len - 1);
      end
    end
  endtask

  // result side: random back-pressure
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    #20_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    int       phase_start;
    cfg_val_t hw, eh, ed;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cam_x <= '0;
    in_cam_y <= '0;
    in_cam_z <= '0;
    in_cube_x <= '0;
    in_cube_y <= '0;
    in_cube_z <= '0;
    in_last <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_BOX_HALF_WIDTH;
    cfg_wdata <= '0;
    calm = 1'b0;
    words_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed scans under reset register values
    // three-way tie on overlap goes to x
    send_word(0, 0, 0, 12107, -1000, 12107, 1'b1);
    // y and z tie, both below x
    send_word(0, 0, 0, 0, -1000, 12107, 1'b1);
    // z alone least
    send_word(0, 0, 0, 0, -1000, 12607, 1'b1);
    // x alone least
    send_word(0, 0, 0, 12107, -20000, 0, 1'b1);
    // touching faces only, then a far cube with a moved camera: no hit
    send_word(0, 0, 0, 13107, -1000, 0, 1'b0);
    send_word(5 * ONE, 2 * ONE, -3 * ONE, -40 * ONE, 9 * ONE, 7 * ONE, 1'b1);
    // first hit wins, a later hit and the final camera are ignored
    send_word(0, 0, 0, 12107, -1000, 12107, 1'b0);
    send_word(ONE, ONE, ONE, ONE + 12107, ONE - 1000, ONE + 12107, 1'b0);
    send_word(10 * ONE, 10 * ONE, 10 * ONE, -50 * ONE, -50 * ONE, -50 * ONE, 1'b1);
    // miss, then a hit from a moved camera
    send_word(0, 0, 0, 5 * ONE, 5 * ONE, 5 * ONE, 1'b0);
    send_word(3 * ONE, 2 * ONE, -ONE, 3 * ONE - ONE + 300, 2 * ONE - 800, -ONE, 1'b1);
    // extreme positions, saturating corners and push
    send_word(Q_TOP, Q_TOP, Q_TOP, Q_TOP - 100, Q_TOP - 100, Q_TOP - 100, 1'b1);
    send_word(Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT, 1'b1);
    send_word(Q_TOP, Q_TOP, Q_TOP, Q_BOT, Q_BOT, Q_BOT, 1'b1);
    send_word(Q_BOT, Q_BOT, Q_BOT, Q_TOP, Q_TOP, Q_TOP, 1'b1);
    send_word(32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
              32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 1'b1);
    settle();

    // random scans, one register setting per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      calm = (p == 5) || (p == 9);
      case (p)
        0: begin
          hw = RST_BOX_HALF_WIDTH;
          eh = RST_EYE_HEIGHT;
          ed = RST_CUBE_EDGE;
        end
        1: begin
          hw = '0;
          eh = '0;
          ed = '0;
        end
        2: begin
          hw = CFG_TOP;
          eh = CFG_TOP;
          ed = CFG_TOP;
        end
        3: begin
          hw = '0;
          eh = RST_EYE_HEIGHT;
          ed = RST_CUBE_EDGE;
        end
        4: begin
          hw = RST_BOX_HALF_WIDTH;
          eh = cfg_val_t'($urandom_range(0, 2 * ONE));
          ed = CFG_TOP;
        end
        6: begin
          hw = cfg_val_t'($urandom);
          eh = cfg_val_t'($urandom);
          ed = cfg_val_t'($urandom);
        end
        7: begin
          hw = cfg_val_t'($urandom_range(1, ONE));
          eh = CFG_TOP;
          ed = cfg_val_t'($urandom_range(1, 2 * ONE));
        end
        default: begin
          hw = cfg_val_t'($urandom_range(0, 4 * ONE));
          eh = cfg_val_t'($urandom_range(0, 8 * ONE));
          ed = cfg_val_t'($urandom_range(1, 4 * ONE));
        end
      endcase
      set_regs(hw, eh, ed);
      phase_start = words_sent;
      while (words_sent - phase_start < WORDS_PER_PHASE) run_scan();
      settle();
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
